>>> src/sliding_median_spike_detector_unit_assert.svh
`ifndef SLIDING_MEDIAN_SPIKE_DETECTOR_UNIT_ASSERT_SVH
`define SLIDING_MEDIAN_SPIKE_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication on clk, off during reset
`define SMSD_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, off during reset
`define SMSD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/smsd_pkg.sv
package smsd_pkg;

  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned MDBL_W      = 9;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [APB_AW-3:0] REG_WINDOW_LENGTH = '0;

  typedef struct packed {
    logic flush;
    logic clear;
    logic accept;
    logic walk;
    logic ring;
    logic old_rd;
    logic old_wr;
    logic new_rd;
    logic new_wr;
    logic finish;
  } smsd_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic walk_done;
    logic item_full;
    logic out_free;
  } smsd_sts_t;

endpackage

>>> src/sliding_median_spike_detector_unit.sv
// per word: once the window is full, a histogram walk (one bin a cycle) finds the median,
//   then the ring and histogram are updated and the output word is registered
// one word at a time: a new input word is taken only once the last output word is registered
// reset: synchronous; a clearing pass over every histogram bin follows reset and
//   every window_length write, with s_axis_tready low; alert count kept on write
`include "sliding_median_spike_detector_unit_assert.svh"

module sliding_median_spike_detector_unit
  import smsd_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 1024,
  parameter int unsigned VALUE_LEVELS = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample[7:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // window_full[0], alert[1], median_doubled[10:2], alert_count[42:11], zero[47:43]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [CFG_W-1:0]   window_length;
  logic               cfg_flush;
  smsd_cmd_t          cmd;
  smsd_sts_t          sts;
  logic               window_full;
  logic               alert;
  logic [MDBL_W-1:0]  median_doubled;
  logic [TOTAL_W-1:0] alert_count;

  assign pready    = 1'b1;
  assign cfg_flush = psel && penable && pwrite && pready
                     && (paddr[APB_AW-1:2] == REG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= CFG_W'(1);
    end else if (cfg_flush) begin
      window_length <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[APB_AW-1:2] == REG_WINDOW_LENGTH) ? APB_DW'(window_length) : '0;

  smsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_flush (cfg_flush),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  smsd_datapath #(
    .WINDOW_MAX   (WINDOW_MAX),
    .VALUE_LEVELS (VALUE_LEVELS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .window_length  (window_length),
    .sample         (s_axis_tdata[SAMPLE_W-1:0]),
    .out_ready      (m_axis_tready),
    .out_valid      (m_axis_tvalid),
    .window_full    (window_full),
    .alert          (alert),
    .median_doubled (median_doubled),
    .alert_count    (alert_count)
  );

  assign m_axis_tdata = {5'd0, alert_count, median_doubled, alert, window_full};

  `SMSD_ASSERT_NEXT(a_flush_blocks_input, cfg_flush, !s_axis_tready, "input open after flush")
  `SMSD_ASSERT_NEXT(a_one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken during work")
  `SMSD_ASSERT_SAME(a_alert_needs_full, m_axis_tvalid && alert, window_full, "alert without full window")
  `SMSD_ASSERT_SAME(a_median_zero_unfilled, m_axis_tvalid && !window_full, median_doubled == '0, "median on unfilled window")

endmodule

>>> src/smsd_ctrl.sv
module smsd_ctrl
  import smsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_flush,
  input  logic      in_valid,
  output logic      in_ready,
  input  smsd_sts_t sts,
  output smsd_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RING,
    ST_OLD_RD,
    ST_OLD_WR,
    ST_NEW_RD,
    ST_NEW_WR,
    ST_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else if (cfg_flush) begin
      state <= ST_CLEAR;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (sts.clear_done) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) state <= ST_WALK;
        end
        ST_WALK: begin
          if (!sts.item_full || sts.walk_done) state <= ST_RING;
        end
        ST_RING: begin
          state <= sts.item_full ? ST_OLD_RD : ST_NEW_RD;
        end
        ST_OLD_RD: state <= ST_OLD_WR;
        ST_OLD_WR: state <= ST_NEW_RD;
        ST_NEW_RD: state <= ST_NEW_WR;
        ST_NEW_WR: state <= ST_DONE;
        ST_DONE: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.flush = cfg_flush;
    in_ready  = 1'b0;
    case (state)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_WALK:   cmd.walk   = sts.item_full;
      ST_RING:   cmd.ring   = 1'b1;
      ST_OLD_RD: cmd.old_rd = 1'b1;
      ST_OLD_WR: cmd.old_wr = 1'b1;
      ST_NEW_RD: cmd.new_rd = 1'b1;
      ST_NEW_WR: cmd.new_wr = 1'b1;
      ST_DONE:   cmd.finish = sts.out_free;
      default:   cmd.clear  = 1'b0;
    endcase
  end

endmodule

>>> src/smsd_datapath.sv
module smsd_datapath
  import smsd_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 1024,
  parameter int unsigned VALUE_LEVELS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  smsd_cmd_t           cmd,
  output smsd_sts_t           sts,
  input  logic [CFG_W-1:0]    window_length,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                window_full,
  output logic                alert,
  output logic [MDBL_W-1:0]   median_doubled,
  output logic [TOTAL_W-1:0]  alert_count
);

  localparam int unsigned LW = $clog2(VALUE_LEVELS);
  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned RW = $clog2(WINDOW_MAX);
  localparam logic [LW-1:0] LEVEL_MAX = LW'(VALUE_LEVELS - 1);
  localparam logic [CW-1:0] LEN_MAX   = CW'(WINDOW_MAX);

  // histogram and sample ring
  logic [CW-1:0] hist [VALUE_LEVELS];
  logic [LW-1:0] ring [WINDOW_MAX];
  logic [CW-1:0] hist_rdata;
  logic [LW-1:0] ring_rdata;
  logic          hist_we;
  logic [LW-1:0] hist_waddr;
  logic [LW-1:0] hist_raddr;
  logic [CW-1:0] hist_wdata;

  logic [CW-1:0] len;
  logic [CW-1:0] k_hi;
  logic [CW-1:0] k_lo;
  logic [LW-1:0] s_clamped;
  logic [LW-1:0] s_reg;
  logic          item_full;
  logic [CW-1:0] fill;
  logic [RW-1:0] idx;
  logic [CW-1:0] idx_inc;
  logic [LW-1:0] clear_addr;
  logic          clear_done;

  logic [LW-1:0] walk_addr;
  logic [LW-1:0] pend_addr;
  logic          rd_pend;
  logic          issued_all;
  logic [CW-1:0] seen;
  logic [CW-1:0] seen_sum;
  logic          lo_found;
  logic          hi_found;
  logic [LW-1:0] lo;
  logic [LW-1:0] hi;

  logic [LW:0]          mdbl;
  logic                 alert_now;
  logic [TOTAL_W-1:0]   alert_total;
  logic [TOTAL_W-1:0]   total_next;

  always_comb begin
    if (window_length == '0) begin
      len = CW'(1);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      len = LEN_MAX;
    end else begin
      len = CW'(window_length);
    end
    k_hi = len >> 1;
    k_lo = len[0] ? k_hi : k_hi - CW'(1);
  end

  assign s_clamped  = (32'(sample) >= 32'(VALUE_LEVELS)) ? LEVEL_MAX : LW'(sample);
  assign clear_done = (clear_addr == LEVEL_MAX);
  assign seen_sum   = seen + hist_rdata;
  assign idx_inc    = CW'(idx) + CW'(1);

  assign mdbl       = (LW + 1)'(lo) + (LW + 1)'(hi);
  assign alert_now  = item_full && ((LW + 1)'(s_reg) >= mdbl);
  assign total_next = (alert_now && (alert_total != '1)) ? alert_total + 32'd1 : alert_total;

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = clear_addr;
    hist_wdata = '0;
    hist_raddr = walk_addr;
    if (cmd.clear) begin
      hist_we = 1'b1;
    end else if (cmd.old_wr) begin
      hist_we    = (hist_rdata != '0);
      hist_waddr = ring_rdata;
      hist_wdata = hist_rdata - CW'(1);
    end else if (cmd.new_wr) begin
      hist_we    = 1'b1;
      hist_waddr = s_reg;
      hist_wdata = hist_rdata + CW'(1);
    end
    if (cmd.old_rd) begin
      hist_raddr = ring_rdata;
    end else if (cmd.new_rd) begin
      hist_raddr = s_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist[hist_waddr] <= hist_wdata;
    hist_rdata <= hist[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ring) begin
      ring_rdata <= ring[idx];
      ring[idx]  <= s_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr  <= '0;
      fill        <= '0;
      idx         <= '0;
      alert_total <= '0;
      out_valid   <= 1'b0;
      walk_addr   <= '0;
      rd_pend     <= 1'b0;
      issued_all  <= 1'b0;
      lo_found    <= 1'b0;
      hi_found    <= 1'b0;
      item_full   <= 1'b0;
    end else begin
      if (cmd.flush) begin
        clear_addr <= '0;
      end else if (cmd.clear) begin
        clear_addr <= clear_done ? '0 : clear_addr + LW'(1);
      end

      if (cmd.accept) begin
        s_reg      <= s_clamped;
        item_full  <= (fill >= len);
        walk_addr  <= '0;
        rd_pend    <= 1'b0;
        issued_all <= 1'b0;
        seen       <= '0;
        lo_found   <= 1'b0;
        hi_found   <= 1'b0;
        lo         <= LEVEL_MAX;
        hi         <= LEVEL_MAX;
      end

      // one bin read issued per cycle, its registered data checked in the next cycle
      if (cmd.walk) begin
        rd_pend   <= !issued_all;
        pend_addr <= walk_addr;
        if (!issued_all) begin
          if (walk_addr == LEVEL_MAX) begin
            issued_all <= 1'b1;
          end else begin
            walk_addr <= walk_addr + LW'(1);
          end
        end
        if (rd_pend) begin
          seen <= seen_sum;
          if (!lo_found && (seen_sum > k_lo)) begin
            lo       <= pend_addr;
            lo_found <= 1'b1;
          end
          if (!hi_found && (seen_sum > k_hi)) begin
            hi       <= pend_addr;
            hi_found <= 1'b1;
          end
        end
      end

      if (cmd.flush) begin
        fill <= '0;
        idx  <= '0;
      end else if (cmd.finish) begin
        if (!item_full) fill <= fill + CW'(1);
        idx         <= (idx_inc >= len) ? '0 : RW'(idx_inc);
        alert_total <= total_next;
      end

      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      window_full    <= item_full;
      alert          <= alert_now;
      median_doubled <= item_full ? MDBL_W'(mdbl) : '0;
      alert_count    <= total_next;
    end
  end

  always_comb begin
    sts.clear_done = clear_done;
    sts.walk_done  = hi_found || (issued_all && !rd_pend);
    sts.item_full  = item_full;
    sts.out_free   = !out_valid || out_ready;
  end

endmodule
